// ===== rtl/core/ptb_pkg.sv =====
// Shared types, widths and codes for the periodic task timer bank.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package ptb_pkg;

    // Field and state widths
    localparam int TIME_W      = 48;
    localparam int IVL_W       = 32;
    localparam int CNT_W       = 20;
    localparam int USED_W      = 5;
    localparam int SSTEP_W     = 8;
    localparam int FSTEP_W     = 20;
    localparam int CFG_W       = 20;
    localparam int CFG_IDX_W   = 2;
    localparam int IDX_OUT_W   = 4;
    localparam int KIND_W      = 2;
    localparam int NCNT_W      = 6;

    // Limits and defaults
    localparam int TASKS_PER_BANK_DEF = 16;
    localparam int MAX_RESULTS        = 32;

    localparam logic [SSTEP_W-1:0] SLOW_STEP_RST  = 8'd1;
    localparam logic [FSTEP_W-1:0] FAST_STEP_RST  = 20'd100000;
    localparam logic [CNT_W-1:0]   TICKS_SLOW_RST = 20'd10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_STEP      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_STEP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SLOW = 2'd2;

    // Input opcodes
    localparam logic OP_REGISTER = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    // Bank codes
    localparam logic BANK_SLOW = 1'b0;
    localparam logic BANK_FAST = 1'b1;

    // Result kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_REGISTERED = 2'd0,
        KIND_FIRED      = 2'd1,
        KIND_IDLE       = 2'd2,
        KIND_FULL       = 2'd3
    } kind_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REGISTER,
        ST_BANK_START,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic do_register;
        logic bank_start;
        logic scan;
        logic next_bank;
        logic flush;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
        logic scan_done;
        logic more_bank;
    } sts_t;

endpackage

// ===== rtl/core/ptb_if.sv =====
// Valid/ready channel interfaces for task requests and results.
// Depends on ptb_pkg for field widths.
interface ptb_req_if;
    logic                       valid;
    logic                       ready;
    logic                       opcode;
    logic                       bank;
    logic [ptb_pkg::IVL_W-1:0]  interval;

    modport source (output valid, output opcode, output bank, output interval, input ready);
    modport sink   (input valid, input opcode, input bank, input interval, output ready);
endinterface

interface ptb_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ptb_pkg::KIND_W-1:0]    kind;
    logic                          bank_res;
    logic [ptb_pkg::IDX_OUT_W-1:0] task_index;
    logic                          last;

    modport source (output valid, output kind, output bank_res, output task_index,
                    output last, input ready);
    modport sink   (input valid, input kind, input bank_res, input task_index,
                    input last, output ready);
endinterface

// ===== rtl/core/ptb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/ptb_ctrl.sv =====
// Controller state machine: sequences task registration and the per-bank scan.
// Depends on ptb_pkg for state, command and status types.
module ptb_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_opcode,
    output logic          in_ready,
    input  ptb_pkg::sts_t sts,
    output ptb_pkg::cmd_t cmd
);

    ptb_pkg::state_t state_reg;
    ptb_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ptb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ptb_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_opcode == ptb_pkg::OP_TICK) ? ptb_pkg::ST_BANK_START
                                                                 : ptb_pkg::ST_REGISTER;
                end
            end
            ptb_pkg::ST_REGISTER:
            begin
                if (sts.out_free)
                begin
                    state_next = ptb_pkg::ST_IDLE;
                end
            end
            ptb_pkg::ST_BANK_START:
            begin
                state_next = ptb_pkg::ST_SCAN;
            end
            ptb_pkg::ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = sts.more_bank ? ptb_pkg::ST_BANK_START : ptb_pkg::ST_FLUSH;
                end
            end
            ptb_pkg::ST_FLUSH:
            begin
                if (sts.out_free)
                begin
                    state_next = ptb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptb_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready        = 1'b0;
        cmd             = '0;
        case (state_reg)
            ptb_pkg::ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            ptb_pkg::ST_REGISTER:
            begin
                cmd.do_register = sts.out_free;
            end
            ptb_pkg::ST_BANK_START:
            begin
                cmd.bank_start = 1'b1;
            end
            ptb_pkg::ST_SCAN:
            begin
                cmd.scan      = 1'b1;
                cmd.next_bank = sts.scan_done && sts.more_bank;
            end
            ptb_pkg::ST_FLUSH:
            begin
                cmd.flush = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/ptb_dpath.sv =====
// Datapath: configuration, bank times, task tables, due-time scan and result register.
// Depends on ptb_pkg and ptb_ram.
module ptb_dpath #(
    parameter int TASKS_PER_BANK = ptb_pkg::TASKS_PER_BANK_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ptb_pkg::cmd_t                     cmd,
    output ptb_pkg::sts_t                     sts,
    input  logic                              cfg_we,
    input  logic [ptb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ptb_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_opcode,
    input  logic                              in_bank,
    input  logic [ptb_pkg::IVL_W-1:0]         in_interval,
    input  logic                              out_ready,
    output logic                              out_valid,
    output ptb_pkg::kind_t                    out_kind,
    output logic                              out_bank_res,
    output logic [ptb_pkg::IDX_OUT_W-1:0]     out_task_index,
    output logic                              out_last
);

    localparam int DEPTH = 2 * TASKS_PER_BANK;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ptb_pkg::USED_W:0]   TPB_EXT  = (ptb_pkg::USED_W + 1)'(TASKS_PER_BANK);
    localparam logic [ptb_pkg::USED_W:0]   LAST_IDX = (ptb_pkg::USED_W + 1)'(TASKS_PER_BANK - 1);
    localparam logic [ptb_pkg::NCNT_W-1:0] MAX_RES  = ptb_pkg::NCNT_W'(ptb_pkg::MAX_RESULTS);

    // Table slot of a task index within a bank
    function automatic logic [AW-1:0] slot_of(input logic b,
                                              input logic [ptb_pkg::USED_W-1:0] idx);
        logic [AW-1:0] base;
        base = b ? AW'(TASKS_PER_BANK) : '0;
        return base + AW'(idx);
    endfunction

    // Configuration registers
    logic [ptb_pkg::SSTEP_W-1:0] slow_step_reg;
    logic [ptb_pkg::FSTEP_W-1:0] fast_step_reg;
    logic [ptb_pkg::CNT_W-1:0]   ticks_slow_reg;

    // Bank state
    logic [ptb_pkg::TIME_W-1:0]  slow_time_reg;
    logic [ptb_pkg::TIME_W-1:0]  fast_time_reg;
    logic [ptb_pkg::CNT_W-1:0]   base_cnt_reg;
    logic [ptb_pkg::USED_W-1:0]  slow_used_reg;
    logic [ptb_pkg::USED_W-1:0]  fast_used_reg;

    // Item and scan state
    logic                        bank_reg;
    logic [ptb_pkg::IVL_W-1:0]   ivl_reg;
    logic                        cur_bank_reg;
    logic                        more_reg;
    logic [ptb_pkg::USED_W-1:0]  chk_idx_reg;
    logic [ptb_pkg::NCNT_W-1:0]  n_cnt_reg;
    logic                        pend_valid_reg;
    logic                        pend_bank_reg;
    logic [ptb_pkg::IDX_OUT_W-1:0] pend_idx_reg;

    // Result register
    logic                          out_valid_reg;
    ptb_pkg::kind_t                out_kind_reg;
    logic                          out_bank_reg;
    logic [ptb_pkg::IDX_OUT_W-1:0] out_idx_reg;
    logic                          out_last_reg;

    // Combinational
    logic [ptb_pkg::CNT_W-1:0]   ratio;
    logic [ptb_pkg::CNT_W-1:0]   base_cnt_next;
    logic                        slow_tick;
    logic                        ratio_one;
    logic [ptb_pkg::USED_W-1:0]  used_cur;
    logic [ptb_pkg::USED_W-1:0]  reg_used;
    logic                        bank_full;
    logic [ptb_pkg::TIME_W-1:0]  now;
    logic [ptb_pkg::TIME_W-1:0]  due_rd;
    logic [ptb_pkg::IVL_W-1:0]   ivl_rd;
    logic [ptb_pkg::TIME_W-1:0]  due_sum;
    logic                        scan_done;
    logic                        fire;
    logic                        report;
    logic                        out_free;
    logic                        stall;
    logic                        advance;
    logic                        take_fire;
    logic                        load_push;
    logic                        reg_we;
    logic                        due_we;
    logic [AW-1:0]               reg_addr;
    logic [AW-1:0]               chk_addr;
    logic [AW-1:0]               rd_addr;
    logic [ptb_pkg::USED_W-1:0]  rd_idx;
    logic [AW-1:0]               due_wr_addr;
    logic [ptb_pkg::TIME_W-1:0]  due_wr_data;

    // Slow tick decision for the incoming tick
    assign ratio         = (ticks_slow_reg == '0) ? ptb_pkg::CNT_W'(1) : ticks_slow_reg;
    assign base_cnt_next = base_cnt_reg + ptb_pkg::CNT_W'(1);
    assign slow_tick     = (base_cnt_next >= ratio);
    assign ratio_one     = (ratio == ptb_pkg::CNT_W'(1));

    // Bank selection
    assign used_cur  = cur_bank_reg ? fast_used_reg : slow_used_reg;
    assign reg_used  = bank_reg ? fast_used_reg : slow_used_reg;
    assign bank_full = ({1'b0, reg_used} >= TPB_EXT);
    assign now       = cur_bank_reg ? fast_time_reg : slow_time_reg;

    // Due check on the entry under scan
    assign out_free  = !out_valid_reg || out_ready;
    assign scan_done = (chk_idx_reg >= used_cur);
    assign fire      = cmd.scan && !scan_done && (now >= due_rd);
    assign report    = (n_cnt_reg < MAX_RES);
    assign stall     = fire && report && pend_valid_reg && !out_free;
    assign advance   = cmd.scan && !scan_done && !stall;
    assign take_fire = advance && fire && report;
    assign load_push = take_fire && pend_valid_reg;
    assign due_sum   = now + ptb_pkg::TIME_W'(ivl_rd);

    // Table addressing: hold the read address while stalled
    assign reg_addr    = slot_of(bank_reg, reg_used);
    assign chk_addr    = slot_of(cur_bank_reg, chk_idx_reg);
    assign rd_idx      = (advance && ({1'b0, chk_idx_reg} != LAST_IDX))
                         ? chk_idx_reg + ptb_pkg::USED_W'(1) : chk_idx_reg;
    assign rd_addr     = cmd.bank_start ? slot_of(cur_bank_reg, '0)
                                        : slot_of(cur_bank_reg, rd_idx);
    assign reg_we      = cmd.do_register && !bank_full;
    assign due_we      = reg_we || (advance && fire);
    assign due_wr_addr = cmd.do_register ? reg_addr : chk_addr;
    assign due_wr_data = cmd.do_register ? ptb_pkg::TIME_W'(ivl_reg) : due_sum;

    ptb_ram #(
        .WIDTH (ptb_pkg::IVL_W),
        .DEPTH (DEPTH)
    ) u_ivl_ram (
        .clk     (clk),
        .we      (reg_we),
        .wr_addr (reg_addr),
        .wr_data (ivl_reg),
        .rd_addr (rd_addr),
        .rd_data (ivl_rd)
    );

    ptb_ram #(
        .WIDTH (ptb_pkg::TIME_W),
        .DEPTH (DEPTH)
    ) u_due_ram (
        .clk     (clk),
        .we      (due_we),
        .wr_addr (due_wr_addr),
        .wr_data (due_wr_data),
        .rd_addr (rd_addr),
        .rd_data (due_rd)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_step_reg  <= ptb_pkg::SLOW_STEP_RST;
            fast_step_reg  <= ptb_pkg::FAST_STEP_RST;
            ticks_slow_reg <= ptb_pkg::TICKS_SLOW_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ptb_pkg::CFG_SLOW_STEP:      slow_step_reg  <= cfg_data[ptb_pkg::SSTEP_W-1:0];
                ptb_pkg::CFG_FAST_STEP:      fast_step_reg  <= cfg_data[ptb_pkg::FSTEP_W-1:0];
                ptb_pkg::CFG_TICKS_PER_SLOW: ticks_slow_reg <= cfg_data[ptb_pkg::CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Latch the accepted item
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            bank_reg <= in_bank;
            ivl_reg  <= in_interval;
        end
    end

    // Bank times, tick counter, fill counts and scan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slow_time_reg  <= '0;
            fast_time_reg  <= '0;
            base_cnt_reg   <= '0;
            slow_used_reg  <= '0;
            fast_used_reg  <= '0;
            cur_bank_reg   <= ptb_pkg::BANK_SLOW;
            more_reg       <= 1'b0;
            chk_idx_reg    <= '0;
            n_cnt_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            // Plan the bank order for a tick
            if (cmd.load_item && (in_opcode == ptb_pkg::OP_TICK))
            begin
                base_cnt_reg   <= slow_tick ? '0 : base_cnt_next;
                cur_bank_reg   <= ratio_one ? ptb_pkg::BANK_SLOW : ptb_pkg::BANK_FAST;
                more_reg       <= ratio_one ? 1'b1 : slow_tick;
                n_cnt_reg      <= '0;
                pend_valid_reg <= 1'b0;
            end

            // Append a task
            if (reg_we)
            begin
                if (bank_reg == ptb_pkg::BANK_FAST)
                begin
                    fast_used_reg <= fast_used_reg + ptb_pkg::USED_W'(1);
                end
                else
                begin
                    slow_used_reg <= slow_used_reg + ptb_pkg::USED_W'(1);
                end
            end

            // Advance the bank time and restart the scan
            if (cmd.bank_start)
            begin
                chk_idx_reg <= '0;
                if (cur_bank_reg == ptb_pkg::BANK_FAST)
                begin
                    fast_time_reg <= fast_time_reg + ptb_pkg::TIME_W'(fast_step_reg);
                end
                else
                begin
                    slow_time_reg <= slow_time_reg + ptb_pkg::TIME_W'(slow_step_reg);
                end
            end

            // Step through the table
            if (advance)
            begin
                chk_idx_reg <= chk_idx_reg + ptb_pkg::USED_W'(1);
            end

            // Count reported fires and keep the newest one pending
            if (take_fire)
            begin
                n_cnt_reg      <= n_cnt_reg + ptb_pkg::NCNT_W'(1);
                pend_valid_reg <= 1'b1;
            end

            if (cmd.next_bank)
            begin
                cur_bank_reg <= ~cur_bank_reg;
                more_reg     <= 1'b0;
            end

            if (cmd.flush)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // Pending fire payload
    always_ff @(posedge clk)
    begin
        if (take_fire)
        begin
            pend_bank_reg <= cur_bank_reg;
            pend_idx_reg  <= chk_idx_reg[ptb_pkg::IDX_OUT_W-1:0];
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.do_register || load_push || cmd.flush)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (cmd.do_register)
        begin
            out_kind_reg <= bank_full ? ptb_pkg::KIND_FULL : ptb_pkg::KIND_REGISTERED;
            out_bank_reg <= bank_reg;
            out_idx_reg  <= bank_full ? '0 : reg_used[ptb_pkg::IDX_OUT_W-1:0];
            out_last_reg <= 1'b1;
        end
        else if (load_push)
        begin
            out_kind_reg <= ptb_pkg::KIND_FIRED;
            out_bank_reg <= pend_bank_reg;
            out_idx_reg  <= pend_idx_reg;
            out_last_reg <= 1'b0;
        end
        else if (cmd.flush)
        begin
            out_kind_reg <= pend_valid_reg ? ptb_pkg::KIND_FIRED : ptb_pkg::KIND_IDLE;
            out_bank_reg <= pend_valid_reg ? pend_bank_reg : ptb_pkg::BANK_SLOW;
            out_idx_reg  <= pend_valid_reg ? pend_idx_reg : '0;
            out_last_reg <= 1'b1;
        end
    end

    assign sts.out_free   = out_free;
    assign sts.scan_done  = scan_done;
    assign sts.more_bank  = more_reg;

    assign out_valid      = out_valid_reg;
    assign out_kind       = out_kind_reg;
    assign out_bank_res   = out_bank_reg;
    assign out_task_index = out_idx_reg;
    assign out_last       = out_last_reg;

    // Reported fires never pass the result limit
    a_ncnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        n_cnt_reg <= MAX_RES)
        else $error("fire count above result limit");

    // A stalled entry is not rescheduled
    a_stall_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        stall |-> !due_we)
        else $error("due time written during stall");

    // The closing result of a tick carries last
    a_flush_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.flush |=> (out_valid_reg && out_last_reg))
        else $error("flush did not present a last result");

    // The scan never runs past the bank fill
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> (chk_idx_reg <= used_cur))
        else $error("scan index beyond bank fill");

endmodule

// ===== rtl/core/periodic_task_timer_bank.sv =====
// Periodic task timer bank: top level joining controller and datapath.
// Depends on ptb_pkg, ptb_if, ptb_ctrl, ptb_dpath and ptb_ram.
//
// Usage:
//   req carries one item per transfer: opcode register (bank, interval) or
//   tick. rsp carries result transfers; the final one of each item has last.
//   A register item gives one result (registered or bank full), once the
//   result register is free. A tick advances the fast time, and every
//   ticks_per_slow ticks the slow time; each served bank walks its task
//   table one entry per cycle, unless a waiting result stalls the walk,
//   through the shared read address of the interval and due-time RAMs.
//   A tick runs a bank start and a scan per served bank, then a flush.
//   Fired tasks stream out in table order; a tick with no fire gives one
//   idle result. One item is in work at a time; req is ready only between
//   items.
//   A stalled rsp holds the current result; the table walk pauses when a
//   further result is waiting for the register, with nothing lost.
//   cfg_we/cfg_index/cfg_data write slow_step, fast_step, ticks_per_slow;
//   write only while idle. Reset clears times, counters and fill counts and
//   loads the register defaults; task entries are used only after written.
module periodic_task_timer_bank #(
    parameter int TASKS_PER_BANK = ptb_pkg::TASKS_PER_BANK_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ptb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ptb_pkg::CFG_W-1:0]     cfg_data,
    ptb_req_if.sink                       req,
    ptb_rsp_if.source                     rsp
);

    ptb_pkg::cmd_t  cmd;
    ptb_pkg::sts_t  sts;
    ptb_pkg::kind_t kind;

    // Sequencing
    ptb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_opcode (req.opcode),
        .in_ready  (req.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Tables, times and result register
    ptb_dpath #(
        .TASKS_PER_BANK (TASKS_PER_BANK)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_opcode      (req.opcode),
        .in_bank        (req.bank),
        .in_interval    (req.interval),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .out_kind       (kind),
        .out_bank_res   (rsp.bank_res),
        .out_task_index (rsp.task_index),
        .out_last       (rsp.last)
    );

    assign rsp.kind = kind;

endmodule
